// ----- design/wwht_pkg.sv -----
// shared constants and types for the weight hash table
`default_nettype none
package wwht_pkg;
  localparam int unsigned TableEntries = 16384;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned SizeW = 15;
  localparam logic [31:0] ZeroKeySubst = 32'hdeadbeef;
  localparam logic [31:0] WeightOne = 32'h0100_0000;
  localparam logic [31:0] PromoReset = 32'd20635976;
  localparam logic [31:0] DemoReset = 32'd13925089;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(16384);

  typedef enum logic [1:0] {
    CfgPromo = 2'd0,
    CfgDemo  = 2'd1,
    CfgSize  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KindLearn  = 1'b0,
    KindLookup = 1'b1
  } kind_e;
endpackage
`default_nettype wire

// ----- design/winnow_weight_hash_table_top.sv -----
// winnow feature weight table with linear probing in one block ram
//  channel | signals                                   | dir | handshake
//  request | start_i kind_i hash_*_i refute_i busy_o   | in  | start_i & !busy_o
//  result  | done_o found_o table_full_o weight_o slot_o| out | done_o, one cycle
//  config  | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in | valid & ready
// after reset a clearing pass empties every memory entry, busy_o high
// a request runs the modulo, then reads and checks a slot per probe, then
// a learn writes a new slot, or multiplies, saturates and writes back a hit
// the memory read port sets the probe step
// results cannot be stalled; one request is in flight at a time
`default_nettype none
module winnow_weight_hash_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] hash_primary_i,
  input  wire logic [31:0] hash_secondary_i,
  input  wire logic        refute_i,
  output logic             done_o,
  output logic             found_o,
  output logic             table_full_o,
  output logic [31:0]      weight_o,
  output logic [13:0]      slot_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import wwht_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StMod, StRead, StCheck, StMul, StSat, StWrite
  } state_e;

  state_e state_q;
  logic [31:0] promo_q, demo_q;
  logic [SizeW-1:0] tsize_q;
  logic [SizeW-1:0] size_q;
  logic kind_q, refute_q;
  logic [31:0] h1_q, h2_q;
  logic [IdxW-1:0] idx_q, home_q;
  logic [SizeW-1:0] n_q;
  logic [63:0] prod_q;
  logic found_q, full_q, done_q;
  logic [31:0] weight_q;
  logic [13:0] slot_q;

  // memory: hash, key, weight
  logic [95:0] mem [TableEntries];
  logic [95:0] rd_q;
  logic        we;
  logic [IdxW-1:0] waddr;
  logic [95:0] wdata;
  logic [IdxW-1:0] raddr;

  logic mod_go, mod_done;
  logic [SizeW-1:0] mod_rem;
  logic [SizeW-1:0] size_use;
  logic [31:0] factor;
  logic [IdxW-1:0] idx_nx;
  logic [SizeW-1:0] idx_nx_w;

  always_comb begin
    if (tsize_q < SizeW'(4)) begin
      size_use = SizeW'(4);
    end else if (tsize_q > SizeW'(TableEntries)) begin
      size_use = SizeW'(TableEntries);
    end else begin
      size_use = tsize_q;
    end
  end

  assign factor = refute_q ? demo_q : promo_q;
  assign idx_nx_w = {1'b0, idx_q} + SizeW'(1);
  assign idx_nx = (idx_nx_w >= size_q) ? '0 : idx_nx_w[IdxW-1:0];
  assign mod_go = (state_q == StIdle) && start_i;
  assign raddr = idx_q;

  wwht_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mod_go),
    .num_i  (hash_primary_i),
    .den_i  (size_use),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = idx_q;
    wdata = {h1_q, h2_q, weight_q};
    if (state_q == StClear) begin
      we = 1'b1;
      wdata = '0;
    end else if (state_q == StWrite) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      promo_q <= PromoReset;
      demo_q <= DemoReset;
      tsize_q <= SizeReset;
      idx_q <= '0;
      done_q <= 1'b0;
      kind_q <= 1'b0;
      refute_q <= 1'b0;
      h1_q <= '0;
      h2_q <= '0;
      size_q <= '0;
      home_q <= '0;
      n_q <= '0;
      prod_q <= '0;
      found_q <= 1'b0;
      full_q <= 1'b0;
      weight_q <= '0;
      slot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgPromo: promo_q <= cfg_data_i;
          CfgDemo:  demo_q <= cfg_data_i;
          CfgSize:  tsize_q <= cfg_data_i[SizeW-1:0];
          default:  ;
        endcase
      end
      unique case (state_q)
        StClear: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == IdxW'(TableEntries - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (start_i) begin
            kind_q <= kind_i;
            refute_q <= refute_i;
            h1_q <= hash_primary_i;
            h2_q <= (hash_secondary_i == '0) ? ZeroKeySubst : hash_secondary_i;
            size_q <= size_use;
            state_q <= StMod;
          end
        end
        StMod: begin
          if (mod_done) begin
            idx_q <= mod_rem[IdxW-1:0];
            home_q <= mod_rem[IdxW-1:0];
            n_q <= '0;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StCheck;
        StCheck: begin
          found_q <= 1'b0;
          full_q <= 1'b0;
          slot_q <= 14'(idx_q);
          if (rd_q[31:0] == '0) begin
            // empty slot ends the probe
            if (kind_q == KindLookup) begin
              weight_q <= WeightOne;
              done_q <= 1'b1;
              state_q <= StIdle;
            end else begin
              weight_q <= (factor == '0) ? 32'd1 : factor;
              state_q <= StWrite;
            end
          end else if (rd_q[95:64] == h1_q && rd_q[63:32] == h2_q) begin
            found_q <= 1'b1;
            if (kind_q == KindLookup) begin
              weight_q <= rd_q[31:0];
              done_q <= 1'b1;
              state_q <= StIdle;
            end else begin
              state_q <= StMul;
            end
          end else if (n_q + SizeW'(1) >= size_q) begin
            slot_q <= 14'(home_q);
            idx_q <= home_q;
            if (kind_q == KindLookup) begin
              weight_q <= WeightOne;
            end else begin
              full_q <= 1'b1;
              weight_q <= '0;
            end
            done_q <= 1'b1;
            state_q <= StIdle;
          end else begin
            n_q <= n_q + SizeW'(1);
            idx_q <= idx_nx;
            state_q <= StRead;
          end
        end
        StMul: begin
          prod_q <= 64'(rd_q[31:0]) * 64'(factor);
          state_q <= StSat;
        end
        StSat: begin
          if (prod_q[63:56] != '0) begin
            weight_q <= 32'hffff_ffff;
          end else if (prod_q[55:24] == '0) begin
            weight_q <= 32'd1;
          end else begin
            weight_q <= prod_q[55:24];
          end
          state_q <= StWrite;
        end
        StWrite: begin
          done_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign done_o = done_q;
  assign found_o = found_q;
  assign table_full_o = full_q;
  assign weight_o = weight_q;
  assign slot_o = slot_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == StIdle)
    else $error("result outside idle");
  a_full_learn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> !found_o && weight_o == '0)
    else $error("full result carries data");
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWrite |=> done_o)
    else $error("write without result");
endmodule
`default_nettype wire

// ----- design/wwht_mod.sv -----
// iterative modulo: remainder of a 32-bit value by the table size, one bit a cycle
`default_nettype none
module wwht_mod (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     go_i,
  input  wire logic [31:0]              num_i,
  input  wire logic [wwht_pkg::SizeW-1:0] den_i,
  output logic                          done_o,
  output logic [wwht_pkg::SizeW-1:0]    rem_o
);
  import wwht_pkg::*;

  logic [31:0] num_q, num_d;
  logic [SizeW:0] rem_q, rem_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [SizeW:0] trial;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[SizeW-1:0], num_q[31]};
    if (go_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o = rem_q[SizeW-1:0];
endmodule
`default_nettype wire
